/* rtl/spf_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// spf_pkg
// Shared types, constants and the prime table of the small prime factorizer.
// ----------------------------------------------------------------------------
package spf_pkg;

  // Table and field geometry
  localparam int SPF_TABLE_SIZE = 54;
  localparam int PRIME_COUNT_DEF = 54;
  localparam int VALUE_BITS_DEF = 32;
  localparam int IDX_W = 6;
  localparam int EXP_W = 5;
  localparam int PRIME_W = 8;
  localparam logic [EXP_W-1:0] EXP_MAX = 5'd31;

  // Dividend bits retired per divider cycle
  localparam int BITS_PER_STEP = 8;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_ZERO   = 2'd1,
    ST_ONE    = 2'd2,
    ST_BEYOND = 2'd3
  } status_t;

  typedef logic [PRIME_W-1:0] prime_arr_t [SPF_TABLE_SIZE];

  localparam prime_arr_t PRIME_TABLE = '{
    8'd2,   8'd3,   8'd5,   8'd7,   8'd11,  8'd13,  8'd17,  8'd19,  8'd23,
    8'd29,  8'd31,  8'd37,  8'd41,  8'd43,  8'd47,  8'd53,  8'd59,  8'd61,
    8'd67,  8'd71,  8'd73,  8'd79,  8'd83,  8'd89,  8'd97,  8'd101, 8'd103,
    8'd107, 8'd109, 8'd113, 8'd127, 8'd131, 8'd137, 8'd139, 8'd149, 8'd151,
    8'd157, 8'd163, 8'd167, 8'd173, 8'd179, 8'd181, 8'd191, 8'd193, 8'd197,
    8'd199, 8'd211, 8'd223, 8'd227, 8'd229, 8'd233, 8'd239, 8'd241, 8'd251
  };

  // Commands from controller to datapath
  typedef struct packed {
    logic    load;        // take a new request
    logic    div_start;   // launch a division with the next operands
    logic    take_q;      // quotient becomes the number, count one more
    logic    exp_write;   // store the current exponent
    logic    idx_inc;     // move to the next prime, clear exponent
    logic    set_status;  // record a special status
    status_t status_code;
    logic    set_highest; // current prime is the last one that divides
    logic    rd_clear;    // restart the exponent readout
    logic    rd_issue;    // read one stored exponent
    logic    rd_inc;      // advance the readout
  } spf_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic div_done;
    logic rem_zero;
    logic num_is_zero;
    logic num_is_one;
    logic idx_last;
    logic res_last;
  } spf_sts_t;

  // Look up one table prime; codes past the table read as the first prime
  function automatic logic [PRIME_W-1:0] spf_prime(input logic [IDX_W-1:0] idx);
    logic [PRIME_W-1:0] p;
    p = PRIME_TABLE[0];
    if (idx < IDX_W'(SPF_TABLE_SIZE)) begin
      p = PRIME_TABLE[idx];
    end
    return p;
  endfunction

endpackage
`default_nettype wire

/* rtl/small_prime_factorizer.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// small_prime_factorizer
// Trial-division factorizer of one unsigned number over the primes 2..251.
//
// A request on in_valid/in_ready carries in_value. Results leave on
// out_valid/out_ready: one per table prime, from 2 up to the largest prime
// that divides the number, each with its exponent, the final one flagged
// by out_last. Zero, one, or a number with a factor above the table give a
// single status result instead. in_ready is high only while no request is
// in progress; one request is worked on at a time.
// Work: one check, then a run of trial divisions in the shared divider;
// the number of divisions is the primes tried plus the sum of the
// exponents. Each prime result is then read from the exponent store and
// presented until the receiver accepts it.
// A stalled receiver holds the current result; work resumes on accept.
// Reset returns the sequencer to idle; nothing else needs clearing.
// ----------------------------------------------------------------------------
module small_prime_factorizer import spf_pkg::*; #(
  parameter int PRIME_COUNT = PRIME_COUNT_DEF,
  parameter int VALUE_BITS  = VALUE_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [VALUE_BITS-1:0] in_value,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic [1:0]                 out_status,
  output logic [IDX_W-1:0]           out_prime_index,
  output logic [EXP_W-1:0]           out_exponent,
  output logic                       out_last
);

  spf_cmd_t cmd;
  spf_sts_t sts;

  // Sequencer
  spf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  // Arithmetic and storage
  spf_datapath #(
    .PRIME_COUNT (PRIME_COUNT),
    .VALUE_BITS  (VALUE_BITS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_value        (in_value),
    .out_status      (out_status),
    .out_prime_index (out_prime_index),
    .out_exponent    (out_exponent),
    .out_last        (out_last)
  );

endmodule
`default_nettype wire

/* rtl/spf_divider.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// spf_divider
// Iterative divider of a wide number by an 8-bit prime, several quotient
// bits per cycle, giving quotient and a zero-remainder flag.
// ----------------------------------------------------------------------------
module spf_divider import spf_pkg::*; #(
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  start,
  input  wire logic [VALUE_BITS-1:0] dividend,
  input  wire logic [PRIME_W-1:0]    divisor,
  output logic                       done,
  output logic [VALUE_BITS-1:0]      quotient,
  output logic                       rem_zero
);

  localparam int DIV_STEPS = (VALUE_BITS + BITS_PER_STEP - 1) / BITS_PER_STEP;
  localparam int PAD_W = DIV_STEPS * BITS_PER_STEP;
  localparam int CNT_W = $clog2(DIV_STEPS + 1);

  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [PAD_W-1:0]   work_r, work_nxt;
  logic [PRIME_W-1:0] rem_r, rem_nxt;
  logic [PRIME_W-1:0] div_r;

  // Shift-subtract over one group of dividend bits
  always_comb begin
    logic [PRIME_W-1:0] r;
    logic [PRIME_W:0]   t;
    logic [PAD_W-1:0]   w;
    r = rem_r;
    w = work_r;
    for (int i = 0; i < BITS_PER_STEP; i++) begin
      t = {r, w[PAD_W-1]};
      w = {w[PAD_W-2:0], 1'b0};
      if (t >= {1'b0, div_r}) begin
        t = t - {1'b0, div_r};
        w[0] = 1'b1;
      end
      r = t[PRIME_W-1:0];
    end
    rem_nxt = r;
    work_nxt = w;
  end

  // Count down the remaining groups
  always_comb begin
    cnt_nxt = cnt_r;
    if (start) begin
      cnt_nxt = CNT_W'(DIV_STEPS);
    end else if (cnt_r != '0) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  // Load operands or advance the partial quotient
  always_ff @(posedge clk) begin
    if (start) begin
      work_r <= PAD_W'(dividend);
      rem_r  <= '0;
      div_r  <= divisor;
    end else if (cnt_r != '0) begin
      work_r <= work_nxt;
      rem_r  <= rem_nxt;
    end
  end

  assign done     = (cnt_r == '0);
  assign quotient = work_r[VALUE_BITS-1:0];
  assign rem_zero = (rem_r == '0);

endmodule
`default_nettype wire

/* rtl/spf_datapath.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// spf_datapath
// Number, prime index and exponent registers, the divider, the exponent
// store and the result registers of the factorizer.
// ----------------------------------------------------------------------------
module spf_datapath import spf_pkg::*; #(
  parameter int PRIME_COUNT = PRIME_COUNT_DEF,
  parameter int VALUE_BITS  = VALUE_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire spf_cmd_t              cmd,
  output spf_sts_t                   sts,
  input  wire logic [VALUE_BITS-1:0] in_value,
  output logic [1:0]                 out_status,
  output logic [IDX_W-1:0]           out_prime_index,
  output logic [EXP_W-1:0]           out_exponent,
  output logic                       out_last
);

  localparam int ADDR_W = (PRIME_COUNT > 1) ? $clog2(PRIME_COUNT) : 1;

  logic [VALUE_BITS-1:0] num_r, num_nxt;
  logic [ADDR_W-1:0]     idx_r, idx_nxt;
  logic [EXP_W-1:0]      exp_r, exp_nxt;
  logic [ADDR_W-1:0]     high_r;
  logic [ADDR_W-1:0]     rd_idx_r;
  logic [EXP_W-1:0]      rd_data_r;
  status_t               status_r;
  logic [EXP_W-1:0]      exp_mem [PRIME_COUNT];

  logic                  div_done;
  logic [VALUE_BITS-1:0] div_q;
  logic                  div_rem_zero;

  // Next number, prime index and exponent
  always_comb begin
    num_nxt = num_r;
    idx_nxt = idx_r;
    exp_nxt = exp_r;
    if (cmd.load) begin
      num_nxt = in_value;
      idx_nxt = '0;
      exp_nxt = '0;
    end else if (cmd.take_q) begin
      num_nxt = div_q;
      if (exp_r != EXP_MAX) begin
        exp_nxt = exp_r + EXP_W'(1);
      end
    end else if (cmd.idx_inc) begin
      idx_nxt = idx_r + ADDR_W'(1);
      exp_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    num_r <= num_nxt;
    idx_r <= idx_nxt;
    exp_r <= exp_nxt;
  end

  // Trial division unit, fed with the operands of the coming step
  spf_divider #(
    .VALUE_BITS(VALUE_BITS)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (num_nxt),
    .divisor  (spf_prime(IDX_W'(idx_nxt))),
    .done     (div_done),
    .quotient (div_q),
    .rem_zero (div_rem_zero)
  );

  // Exponent store
  always_ff @(posedge clk) begin
    if (cmd.exp_write) begin
      exp_mem[idx_r] <= exp_r;
    end
    if (cmd.rd_issue) begin
      rd_data_r <= exp_mem[rd_idx_r];
    end
  end

  // Result bookkeeping
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      status_r <= ST_OK;
    end else if (cmd.set_status) begin
      status_r <= cmd.status_code;
    end
    if (cmd.set_highest) begin
      high_r <= idx_r;
    end
    if (cmd.rd_clear) begin
      rd_idx_r <= '0;
    end else if (cmd.rd_inc) begin
      rd_idx_r <= rd_idx_r + ADDR_W'(1);
    end
  end

  // Drive result fields; a status result carries no prime
  always_comb begin
    out_status = status_r;
    if (status_r == ST_OK) begin
      out_prime_index = IDX_W'(rd_idx_r);
      out_exponent    = rd_data_r;
      out_last        = (rd_idx_r == high_r);
    end else begin
      out_prime_index = '0;
      out_exponent    = '0;
      out_last        = 1'b1;
    end
  end

  // Status toward the controller
  assign sts.div_done    = div_done;
  assign sts.rem_zero    = div_rem_zero;
  assign sts.num_is_zero = (num_r == '0);
  assign sts.num_is_one  = (num_r == VALUE_BITS'(1));
  assign sts.idx_last    = (idx_r == ADDR_W'(PRIME_COUNT - 1));
  assign sts.res_last    = out_last;

endmodule
`default_nettype wire

/* rtl/spf_ctrl.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// spf_ctrl
// Sequencer of the factorizer: takes a request, steps the trial divisions
// and hands the results out one at a time.
// ----------------------------------------------------------------------------
module spf_ctrl import spf_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  wire logic     out_ready,
  output spf_cmd_t      cmd,
  input  wire spf_sts_t sts
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_CHECK = 5'b00010,
    S_DIV   = 5'b00100,
    S_READ  = 5'b01000,
    S_SHOW  = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = (state_r == S_SHOW);

  // Next state and datapath commands
  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    cmd.status_code = ST_OK;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (sts.num_is_zero) begin
          cmd.set_status  = 1'b1;
          cmd.status_code = ST_ZERO;
          state_nxt       = S_SHOW;
        end else if (sts.num_is_one) begin
          cmd.set_status  = 1'b1;
          cmd.status_code = ST_ONE;
          state_nxt       = S_SHOW;
        end else begin
          cmd.div_start = 1'b1;
          state_nxt     = S_DIV;
        end
      end
      S_DIV: begin
        if (sts.div_done) begin
          if (sts.rem_zero) begin
            // divide out once more by the same prime
            cmd.take_q    = 1'b1;
            cmd.div_start = 1'b1;
          end else begin
            cmd.exp_write = 1'b1;
            if (sts.num_is_one) begin
              cmd.set_highest = 1'b1;
              cmd.rd_clear    = 1'b1;
              state_nxt       = S_READ;
            end else if (sts.idx_last) begin
              cmd.set_status  = 1'b1;
              cmd.status_code = ST_BEYOND;
              state_nxt       = S_SHOW;
            end else begin
              cmd.idx_inc   = 1'b1;
              cmd.div_start = 1'b1;
            end
          end
        end
      end
      S_READ: begin
        cmd.rd_issue = 1'b1;
        state_nxt    = S_SHOW;
      end
      S_SHOW: begin
        if (out_ready) begin
          if (sts.res_last) begin
            state_nxt = S_IDLE;
          end else begin
            cmd.rd_inc = 1'b1;
            state_nxt  = S_READ;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule
`default_nettype wire

/* sim/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the small prime factorizer. Each accepted request
// is factored in the bench over its own prime table and the expected per-prime
// exponents are queued. Every result from the block is then matched field by
// field against the oldest queued entry. Directed corner numbers run first,
// then mostly table-smooth random numbers, mixed with numbers that have a large
// factor and raw random words. Both handshake sides idle at random.
// ----------------------------------------------------------------------------
module tb_top import spf_pkg::*;;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int RANDOM_REQUESTS = 300;
  localparam int DRAIN_CYCLES = 64;
  localparam logic [31:0] MAX_WORD = 32'hFFFF_FFFF;

  // Corner numbers: zero, one, extreme powers, extreme primes, misfits
  localparam int DIRECTED_COUNT = 20;
  localparam logic [31:0] DIRECTED_VALUES [DIRECTED_COUNT] = '{
    32'd0, 32'd1, 32'd2, 32'd3, 32'h8000_0000, 32'd251, 32'd3969126001,
    32'hFFFF_FFFF, 32'd253, 32'd257, 32'd223092870, 32'd3486784401, 32'd502,
    32'd60491, 32'd4294967291, 32'd63001, 32'd9699690, 32'd14457349,
    32'hAAAA_AAAA, 32'd65536
  };

  // Expected-result store and factoring predictor
  class factor_scoreboard;
    typedef struct {
      status_t          status;
      logic [IDX_W-1:0] index;
      logic [EXP_W-1:0] exponent;
      logic             last;
    } factor_t;

    factor_t expected_factors[$];
    int      primes[$];
    int      mismatches;

    function new();
      bit is_prime;
      mismatches = 0;
      // Build the table: every prime from 2 to 251
      for (int n = 2; n <= 251; n++) begin
        is_prime = 1'b1;
        for (int d = 2; d * d <= n; d++) begin
          if (n % d == 0) is_prime = 1'b0;
        end
        if (is_prime) primes.push_back(n);
      end
    endfunction

    function int pending();
      return expected_factors.size();
    endfunction

    function void push_expect(status_t st, int idx, int expo, bit last);
      factor_t f;
      f.status   = st;
      f.index    = idx[IDX_W-1:0];
      f.exponent = expo[EXP_W-1:0];
      f.last     = last;
      expected_factors.push_back(f);
    endfunction

    // Factor one accepted request and queue its results
    function void note_request(logic [31:0] value);
      longint unsigned rest;
      int              expo[$];
      int              highest;
      int              e;
      rest = value;
      highest = -1;
      if (rest == 0) begin
        push_expect(ST_ZERO, 0, 0, 1'b1);
      end else if (rest == 1) begin
        push_expect(ST_ONE, 0, 0, 1'b1);
      end else begin
        for (int p = 0; p < primes.size() && highest < 0; p++) begin
          e = 0;
          while (rest % primes[p] == 0) begin
            rest = rest / primes[p];
            if (e < int'(EXP_MAX)) e++;
          end
          expo.push_back(e);
          if (rest == 1) highest = p;
        end
        if (highest < 0) begin
          push_expect(ST_BEYOND, 0, 0, 1'b1);
        end else begin
          for (int p = 0; p <= highest; p++) begin
            push_expect(ST_OK, p, expo[p], p == highest);
          end
        end
      end
    endfunction

    task report(string msg);
      $display("MISMATCH @%0t: %s", $realtime, msg);
      mismatches++;
    endtask

    // Compare one accepted result with the oldest expectation
    task check_result(status_t st, logic [IDX_W-1:0] idx, logic [EXP_W-1:0] expo,
                      logic last);
      factor_t want;
      if (expected_factors.size() == 0) begin
        report($sformatf("result with no request pending (status %0d idx %0d)", st, idx));
        return;
      end
      want = expected_factors.pop_front();
      if (st !== want.status)
        report($sformatf("status %0d, expected %0d", st, want.status));
      if (idx !== want.index)
        report($sformatf("prime_index %0d, expected %0d", idx, want.index));
      if (expo !== want.exponent)
        report($sformatf("exponent %0d at idx %0d, expected %0d", expo, want.index,
                         want.exponent));
      if (last !== want.last)
        report($sformatf("last %0b at idx %0d, expected %0b", last, want.index,
                         want.last));
    endtask
  endclass

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready;
  logic [31:0]          in_value;
  logic                 out_valid;
  logic                 out_ready;
  logic [1:0]           out_status;
  logic [IDX_W-1:0]     out_prime_index;
  logic [EXP_W-1:0]     out_exponent;
  logic                 out_last;

  factor_scoreboard board = new();
  int  stall_cycles;
  int  results_seen;
  bit  send_burst;

  small_prime_factorizer dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_value        (in_value),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_status      (out_status),
    .out_prime_index (out_prime_index),
    .out_exponent    (out_exponent),
    .out_last        (out_last)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic int draw_gap(bit burst);
    return burst ? 0 : $urandom_range(0, 14);
  endfunction

  // Product of random table primes that fits in 32 bits
  function automatic logic [31:0] smooth_value();
    longint unsigned acc;
    int              picks;
    int              idx;
    acc = 1;
    picks = $urandom_range(1, 14);
    repeat (picks) begin
      idx = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 53) : $urandom_range(0, 11);
      if (acc * longint'(board.primes[idx]) <= MAX_WORD)
        acc = acc * longint'(board.primes[idx]);
    end
    return acc[31:0];
  endfunction

  // Drive one request; called right after the previous accept edge
  task automatic send_value(input logic [31:0] value);
    int gap;
    gap = draw_gap(send_burst);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_value <= value;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    board.note_request(value);
  endtask

  // Hold off new requests until every queued result has come back
  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
  endtask

  // Result sink with random stalls and stall-free stretches
  initial begin : result_sink
    int gap;
    out_ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      gap = draw_gap(((results_seen / 40) % 3) == 1);
      @(negedge clk);
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      board.check_result(status_t'(out_status), out_prime_index, out_exponent, out_last);
      results_seen++;
    end
  end

  // Abort when no request or result moves for too long
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
        $display("tb_top NOT OK");
        $finish;
      end
    end
  end

  initial begin : stimulus
    logic [31:0]     value;
    longint unsigned wide;
    int              big;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_value = '0;
    send_burst = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed corners
    for (int i = 0; i < DIRECTED_COUNT; i++) begin
      send_value(DIRECTED_VALUES[i]);
    end
    drain_results();

    // Random numbers, mostly table-smooth
    for (int i = 0; i < RANDOM_REQUESTS; i++) begin
      send_burst = ((i / 30) % 3) == 1;
      case ($urandom_range(0, 9))
        0: value = $urandom();
        1: value = $urandom_range(0, 600);
        2: begin
          // Smooth part times a prime past the table, or the prime alone if too wide
          case ($urandom_range(0, 3))
            0: big = 257;
            1: big = 263;
            2: big = 269;
            default: big = 65537;
          endcase
          wide = longint'(smooth_value()) * big;
          value = (wide <= MAX_WORD) ? wide[31:0] : big;
        end
        default: value = smooth_value();
      endcase
      send_value(value);
      if (i == RANDOM_REQUESTS / 2) drain_results();
    end

    // Finish: wait out every result, then watch for strays
    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (board.mismatches == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
